// ===== hw/rtl/drmc_pkg.sv =====
// Shared types, constants and helpers of the dual relay monoflop controller.
package drmc_pkg;

    // Width of the monoflop period and countdown registers (8 to 64).
    localparam int TIME_WIDTH = 32;

    // Depth of the decoded command queue between front and back.
    localparam int CMD_QUEUE_DEPTH = 4;

    // Depth of the result queue in the back part. It must hold at least two.
    localparam int RES_QUEUE_DEPTH = 4;

    // Opcodes on the input channel. The codes six and seven are unsupported.
    typedef enum logic [2:0] {
        OP_SET_BOTH = 3'd0,
        OP_GET_BOTH = 3'd1,
        OP_SET_MONO = 3'd2,
        OP_GET_MONO = 3'd3,
        OP_SET_ONE  = 3'd4,
        OP_TICK     = 3'd5
    } t_opcode;

    // Result kinds on the output channel.
    typedef enum logic [2:0] {
        KIND_ACK         = 3'd0,
        KIND_LEVELS      = 3'd1,
        KIND_MONO        = 3'd2,
        KIND_BAD_PARAM   = 3'd3,
        KIND_UNSUPPORTED = 3'd4,
        KIND_DONE        = 3'd5
    } t_kind;

    // Command classes after decoding in the front part.
    typedef enum logic [2:0] {
        CLS_SET_BOTH    = 3'd0,
        CLS_GET_BOTH    = 3'd1,
        CLS_SET_MONO    = 3'd2,
        CLS_GET_MONO    = 3'd3,
        CLS_SET_ONE     = 3'd4,
        CLS_TICK        = 3'd5,
        CLS_BAD_PARAM   = 3'd6,
        CLS_UNSUPPORTED = 3'd7
    } t_cmd_class;

    typedef struct packed {
        t_cmd_class            cls;
        logic                  sel;   // 0 addresses relay 1, 1 addresses relay 2
        logic                  lv1;
        logic                  lv2;
        logic [TIME_WIDTH-1:0] dur;
        logic                  calc;
        logic                  msg;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  relay_id;
        logic        level_one;
        logic        level_two;
        logic [31:0] period;
        logic [31:0] remaining;
        logic        last;
    } t_result;

    // Fit a 32-bit port value into the timer width (truncate or zero-extend).
    function automatic logic [TIME_WIDTH-1:0] to_time(input logic [31:0] value);
        logic [TIME_WIDTH+31:0] wide;
        wide = {{TIME_WIDTH{1'b0}}, value};
        return wide[TIME_WIDTH-1:0];
    endfunction

    // Fit a timer value into a 32-bit port field (truncate or zero-extend).
    function automatic logic [31:0] to_port(input logic [TIME_WIDTH-1:0] value);
        logic [TIME_WIDTH+31:0] wide;
        wide = {32'd0, value};
        return wide[31:0];
    endfunction

endpackage

// ===== hw/rtl/drmc_front.sv =====
// Front part: accepts input beats, decodes them and holds one decoded command.
module drmc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2:0]      i_opcode,
    input  logic [7:0]      i_relay_number,
    input  logic            i_first_level,
    input  logic            i_second_level,
    input  logic [31:0]     i_duration,
    input  logic            i_calc_tick,
    input  logic            i_message_tick,
    output logic            o_cmd_valid,
    output drmc_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_ready
);

    logic           r_valid;
    drmc_pkg::t_cmd r_cmd;
    logic           n_valid;
    drmc_pkg::t_cmd n_cmd;
    logic           accept;
    logic           relay_ok;
    logic           keep;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign accept      = i_valid && o_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;
    assign relay_ok    = (i_relay_number == 8'd1) || (i_relay_number == 8'd2);

    always_comb begin
        n_cmd      = '0;
        n_cmd.sel  = (i_relay_number == 8'd2);
        n_cmd.lv1  = i_first_level;
        n_cmd.lv2  = i_second_level;
        n_cmd.dur  = drmc_pkg::to_time(i_duration);
        n_cmd.calc = i_calc_tick;
        n_cmd.msg  = i_message_tick;
        keep       = 1'b1;
        unique case (i_opcode)
            drmc_pkg::OP_SET_BOTH: n_cmd.cls = drmc_pkg::CLS_SET_BOTH;
            drmc_pkg::OP_GET_BOTH: n_cmd.cls = drmc_pkg::CLS_GET_BOTH;
            drmc_pkg::OP_SET_MONO: begin
                n_cmd.cls = relay_ok ? drmc_pkg::CLS_SET_MONO : drmc_pkg::CLS_BAD_PARAM;
            end
            drmc_pkg::OP_GET_MONO: begin
                n_cmd.cls = relay_ok ? drmc_pkg::CLS_GET_MONO : drmc_pkg::CLS_BAD_PARAM;
            end
            drmc_pkg::OP_SET_ONE: begin
                n_cmd.cls = relay_ok ? drmc_pkg::CLS_SET_ONE : drmc_pkg::CLS_BAD_PARAM;
            end
            drmc_pkg::OP_TICK: begin
                // A tick with neither bit set does nothing and is dropped here.
                n_cmd.cls = drmc_pkg::CLS_TICK;
                keep      = i_calc_tick || i_message_tick;
            end
            default: n_cmd.cls = drmc_pkg::CLS_UNSUPPORTED;
        endcase
    end

    always_comb begin
        n_valid = r_valid && !i_cmd_ready;
        if (accept && keep) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== hw/rtl/drmc_cmd_queue.sv =====
// Small FIFO of decoded commands between the front and back parts.
module drmc_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  drmc_pkg::t_cmd i_cmd,
    output logic           o_ready,
    output logic           o_valid,
    output drmc_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    localparam int PtrW = $clog2(drmc_pkg::CMD_QUEUE_DEPTH);
    localparam int CntW = $clog2(drmc_pkg::CMD_QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(drmc_pkg::CMD_QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(drmc_pkg::CMD_QUEUE_DEPTH);

    drmc_pkg::t_cmd  r_mem [drmc_pkg::CMD_QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_cnt;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_cnt != FullCnt);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/drmc_back.sv =====
// Back part: relay and monoflop state, command execution and the result queue.
module drmc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  drmc_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output drmc_pkg::t_result o_result
);

    localparam int TW   = drmc_pkg::TIME_WIDTH;
    localparam int PtrW = $clog2(drmc_pkg::RES_QUEUE_DEPTH);
    localparam int CntW = $clog2(drmc_pkg::RES_QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr  = PtrW'(drmc_pkg::RES_QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] RoomCnt  = CntW'(drmc_pkg::RES_QUEUE_DEPTH - 2);

    // Relay and timer state.
    logic [1:0]    r_level;
    logic [1:0]    r_pending;
    logic [TW-1:0] r_period [2];
    logic [TW-1:0] r_remain [2];
    logic [1:0]    n_level;
    logic [1:0]    n_pending;
    logic [TW-1:0] n_period [2];
    logic [TW-1:0] n_remain [2];

    // Result queue.
    drmc_pkg::t_result r_res_q [drmc_pkg::RES_QUEUE_DEPTH];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_res_cnt;
    logic [PtrW-1:0]   n_wr_ptr;
    logic [PtrW-1:0]   n_rd_ptr;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [CntW-1:0]   n_res_cnt;

    drmc_pkg::t_result res [2];
    logic [1:0]        res_num;
    logic              pop;
    logic              out_pop;
    logic              sel;
    logic              done0;
    logic              done1;

    assign sel       = i_cmd.sel;
    assign pop       = i_cmd_valid && (r_res_cnt <= RoomCnt);
    assign o_cmd_pop = pop;
    assign o_valid   = (r_res_cnt != '0);
    assign o_result  = r_res_q[r_rd_ptr];
    assign out_pop   = o_valid && i_ready;

    always_comb begin
        n_level   = r_level;
        n_pending = r_pending;
        n_period  = r_period;
        n_remain  = r_remain;
        res[0]    = '0;
        res[1]    = '0;
        res_num   = 2'd0;
        done0     = 1'b0;
        done1     = 1'b0;
        if (pop) begin
            unique case (i_cmd.cls)
                drmc_pkg::CLS_SET_BOTH: begin
                    n_level     = {i_cmd.lv2, i_cmd.lv1};
                    n_period[0] = '0;
                    n_period[1] = '0;
                    n_remain[0] = '0;
                    n_remain[1] = '0;
                    res[0].kind = drmc_pkg::KIND_ACK;
                    res_num     = 2'd1;
                end
                drmc_pkg::CLS_GET_BOTH: begin
                    res[0].kind      = drmc_pkg::KIND_LEVELS;
                    res[0].level_one = r_level[0];
                    res[0].level_two = r_level[1];
                    res_num          = 2'd1;
                end
                drmc_pkg::CLS_SET_MONO: begin
                    n_level[sel]  = i_cmd.lv1;
                    n_period[sel] = i_cmd.dur;
                    n_remain[sel] = i_cmd.dur;
                    res[0].kind   = drmc_pkg::KIND_ACK;
                    res_num       = 2'd1;
                end
                drmc_pkg::CLS_GET_MONO: begin
                    res[0].kind      = drmc_pkg::KIND_MONO;
                    res[0].relay_id  = sel ? 2'd2 : 2'd1;
                    res[0].level_one = r_level[sel];
                    res[0].period    = drmc_pkg::to_port(r_period[sel]);
                    res[0].remaining = drmc_pkg::to_port(r_remain[sel]);
                    res_num          = 2'd1;
                end
                drmc_pkg::CLS_SET_ONE: begin
                    n_level[sel]  = i_cmd.lv1;
                    n_period[sel] = '0;
                    n_remain[sel] = '0;
                    res[0].kind   = drmc_pkg::KIND_ACK;
                    res_num       = 2'd1;
                end
                drmc_pkg::CLS_TICK: begin
                    // Countdown step first; an expiry here is reported by the same tick.
                    if (i_cmd.calc) begin
                        for (int i = 0; i < 2; i++) begin
                            if (r_remain[i] != '0) begin
                                n_remain[i] = r_remain[i] - 1'b1;
                                if (r_remain[i] == TW'(1)) begin
                                    n_level[i]   = !r_level[i];
                                    n_pending[i] = 1'b1;
                                end
                            end
                        end
                    end
                    if (i_cmd.msg) begin
                        done0 = n_pending[0];
                        done1 = n_pending[1];
                        n_pending = 2'b00;
                    end
                    if (done0) begin
                        res[0].kind      = drmc_pkg::KIND_DONE;
                        res[0].relay_id  = 2'd1;
                        res[0].level_one = n_level[0];
                    end
                    if (done1) begin
                        res[done0].kind      = drmc_pkg::KIND_DONE;
                        res[done0].relay_id  = 2'd2;
                        res[done0].level_one = n_level[1];
                    end
                    res_num = {1'b0, done0} + {1'b0, done1};
                end
                drmc_pkg::CLS_BAD_PARAM: begin
                    res[0].kind = drmc_pkg::KIND_BAD_PARAM;
                    res_num     = 2'd1;
                end
                drmc_pkg::CLS_UNSUPPORTED: begin
                    res[0].kind = drmc_pkg::KIND_UNSUPPORTED;
                    res_num     = 2'd1;
                end
                default: begin
                    res_num = 2'd0;
                end
            endcase
        end
        res[0].last = (res_num == 2'd1);
        res[1].last = 1'b1;
    end

    always_comb begin
        wr_ptr_next = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        n_wr_ptr    = r_wr_ptr;
        if (res_num == 2'd1) begin
            n_wr_ptr = wr_ptr_next;
        end else if (res_num == 2'd2) begin
            n_wr_ptr = (wr_ptr_next == LastPtr) ? '0 : wr_ptr_next + 1'b1;
        end
        n_rd_ptr = r_rd_ptr;
        if (out_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        n_res_cnt = r_res_cnt + CntW'(res_num) - CntW'(out_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_pending   <= '0;
            r_period[0] <= '0;
            r_period[1] <= '0;
            r_remain[0] <= '0;
            r_remain[1] <= '0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_res_cnt   <= '0;
        end else begin
            r_level   <= n_level;
            r_pending <= n_pending;
            r_period  <= n_period;
            r_remain  <= n_remain;
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_res_cnt <= n_res_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_num != 2'd0) begin
            r_res_q[r_wr_ptr] <= res[0];
        end
        if (res_num == 2'd2) begin
            r_res_q[wr_ptr_next] <= res[1];
        end
    end

endmodule

// ===== hw/rtl/dual_relay_monoflop_controller.sv =====
// Top level of the dual relay monoflop controller.
//
//  Channel  | Handshake          | Beat contents
//  ---------+--------------------+----------------------------------------------
//  input    | i_valid / o_ready  | opcode, relay number, levels, duration, ticks
//  output   | o_valid / i_ready  | kind, relay id, levels, period, remaining, last
//
// One input beat is taken per cycle in steady state while the output is not
// stalled; its first result passes the front register, the command queue and
// the result queue before it reaches the output.
// The result queue in the back part bounds the rate: a command enters execution
// only while that queue has room for two results, and each ready cycle drains one.
// Reset (i_rst_n low at a clock edge) turns both relays off, clears all timers
// and pending done events and empties both queues. Either side may stall freely.
//
// The front part decodes each beat into a command class, catching bad relay
// numbers and unsupported opcodes, and drops ticks that carry neither tick bit
// since they change nothing and produce no result. Decoded commands wait in a
// short queue, so a stalled consumer does not immediately stall the producer.
// The back part holds the relay levels, monoflop periods, countdowns and
// pending done flags. A calculation tick decrements every running countdown;
// one that reaches zero toggles its relay and marks a done event. A message
// tick reports pending done events, relay 1 first, within the same tick.
// Every command yields exactly one result; a tick yields zero to two, and the
// final result of each input beat carries o_last.
module dual_relay_monoflop_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_relay_number,
    input  logic        i_first_level,
    input  logic        i_second_level,
    input  logic [31:0] i_duration,
    input  logic        i_calc_tick,
    input  logic        i_message_tick,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [1:0]  o_relay_id,
    output logic        o_level_one,
    output logic        o_level_two,
    output logic [31:0] o_period,
    output logic [31:0] o_remaining,
    output logic        o_last
);

    logic              front_valid;
    drmc_pkg::t_cmd    front_cmd;
    logic              queue_ready;
    logic              queue_valid;
    drmc_pkg::t_cmd    queue_cmd;
    logic              queue_pop;
    drmc_pkg::t_result result;

    drmc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_relay_number (i_relay_number),
        .i_first_level  (i_first_level),
        .i_second_level (i_second_level),
        .i_duration     (i_duration),
        .i_calc_tick    (i_calc_tick),
        .i_message_tick (i_message_tick),
        .o_cmd_valid    (front_valid),
        .o_cmd          (front_cmd),
        .i_cmd_ready    (queue_ready)
    );

    drmc_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd),
        .i_pop   (queue_pop)
    );

    drmc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (result)
    );

    // Result fields onto their ports.
    assign o_kind      = result.kind;
    assign o_relay_id  = result.relay_id;
    assign o_level_one = result.level_one;
    assign o_level_two = result.level_two;
    assign o_period    = result.period;
    assign o_remaining = result.remaining;
    assign o_last      = result.last;

endmodule

// ===== test/relay_result_checker.sv =====
// Channel monitor that predicts and checks the results of the dual relay monoflop controller.
`timescale 1ns / 100ps

module relay_result_checker
    import drmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_relay_number,
    input  logic        i_first_level,
    input  logic        i_second_level,
    input  logic [31:0] i_duration,
    input  logic        i_calc_tick,
    input  logic        i_message_tick,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [2:0]  i_kind,
    input  logic [1:0]  i_relay_id,
    input  logic        i_level_one,
    input  logic        i_level_two,
    input  logic [31:0] i_period,
    input  logic [31:0] i_remaining,
    input  logic        i_last,
    output int          o_mismatches,
    output int          o_outstanding
);

    localparam logic [7:0] RELAY_ONE = 8'd1;
    localparam logic [7:0] RELAY_TWO = 8'd2;

    logic                  relay_on [2];
    logic [TIME_WIDTH-1:0] mono_period [2];
    logic [TIME_WIDTH-1:0] mono_count [2];
    logic                  done_flag [2];

    t_result expected_results[$];
    int      mismatch_total = 0;
    int      outstanding_total = 0;

    assign o_mismatches  = mismatch_total;
    assign o_outstanding = outstanding_total;

    function automatic t_result make_result(t_kind kind, logic [1:0] rid, logic lv1,
                                            logic lv2, logic [31:0] per, logic [31:0] rem);
        t_result r;
        r.kind      = kind;
        r.relay_id  = rid;
        r.level_one = lv1;
        r.level_two = lv2;
        r.period    = per;
        r.remaining = rem;
        r.last      = 1'b0;
        return r;
    endfunction

    // Applies one accepted request beat to the relay state and queues its results.
    task automatic predict_beat();
        t_result               made [2];
        int                    count;
        logic                  sel;
        logic                  relay_ok;
        logic [TIME_WIDTH-1:0] dur;
        count    = 0;
        sel      = (i_relay_number == RELAY_TWO);
        relay_ok = (i_relay_number == RELAY_ONE) || (i_relay_number == RELAY_TWO);
        dur      = TIME_WIDTH'(i_duration);
        case (i_opcode)
            OP_SET_BOTH: begin
                relay_on[0] = i_first_level;
                relay_on[1] = i_second_level;
                for (int i = 0; i < 2; i++) begin
                    mono_period[i] = '0;
                    mono_count[i]  = '0;
                end
                made[count] = make_result(KIND_ACK, 2'd0, 1'b0, 1'b0, 32'd0, 32'd0);
                count = count + 1;
            end
            OP_GET_BOTH: begin
                made[count] = make_result(KIND_LEVELS, 2'd0, relay_on[0], relay_on[1],
                                          32'd0, 32'd0);
                count = count + 1;
            end
            OP_SET_MONO, OP_GET_MONO, OP_SET_ONE: begin
                if (!relay_ok) begin
                    made[count] = make_result(KIND_BAD_PARAM, 2'd0, 1'b0, 1'b0,
                                              32'd0, 32'd0);
                    count = count + 1;
                end else if (i_opcode == OP_GET_MONO) begin
                    made[count] = make_result(KIND_MONO, i_relay_number[1:0],
                                              relay_on[sel], 1'b0,
                                              32'(mono_period[sel]), 32'(mono_count[sel]));
                    count = count + 1;
                end else begin
                    // A single-relay set behaves as a monoflop of length zero.
                    mono_period[sel] = (i_opcode == OP_SET_MONO) ? dur : '0;
                    mono_count[sel]  = (i_opcode == OP_SET_MONO) ? dur : '0;
                    relay_on[sel]    = i_first_level;
                    made[count] = make_result(KIND_ACK, 2'd0, 1'b0, 1'b0, 32'd0, 32'd0);
                    count = count + 1;
                end
            end
            OP_TICK: begin
                if (i_calc_tick) begin
                    for (int i = 0; i < 2; i++) begin
                        if (mono_count[i] != '0) begin
                            mono_count[i] = mono_count[i] - 1'b1;
                            if (mono_count[i] == '0) begin
                                relay_on[i]  = ~relay_on[i];
                                done_flag[i] = 1'b1;
                            end
                        end
                    end
                end
                if (i_message_tick) begin
                    for (int i = 0; i < 2; i++) begin
                        if (done_flag[i]) begin
                            made[count] = make_result(KIND_DONE, 2'(i + 1), relay_on[i],
                                                      1'b0, 32'd0, 32'd0);
                            count = count + 1;
                            done_flag[i] = 1'b0;
                        end
                    end
                end
            end
            default: begin
                made[count] = make_result(KIND_UNSUPPORTED, 2'd0, 1'b0, 1'b0,
                                          32'd0, 32'd0);
                count = count + 1;
            end
        endcase
        if (count > 0) begin
            made[count - 1].last = 1'b1;
        end
        for (int i = 0; i < count; i++) begin
            expected_results.push_back(made[i]);
        end
    endtask

    task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: result field %s expected %0h actual %0h", $time, field, want, got);
        mismatch_total++;
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual kind %0d",
                     $time, i_kind);
            mismatch_total++;
            return;
        end
        want = expected_results.pop_front();
        if (i_kind !== want.kind) note_mismatch("kind", 32'(want.kind), 32'(i_kind));
        if (i_relay_id !== want.relay_id) begin
            note_mismatch("relay_id", 32'(want.relay_id), 32'(i_relay_id));
        end
        if (i_level_one !== want.level_one) begin
            note_mismatch("level_one", 32'(want.level_one), 32'(i_level_one));
        end
        if (i_level_two !== want.level_two) begin
            note_mismatch("level_two", 32'(want.level_two), 32'(i_level_two));
        end
        if (i_period !== want.period) note_mismatch("period", want.period, i_period);
        if (i_remaining !== want.remaining) begin
            note_mismatch("remaining", want.remaining, i_remaining);
        end
        if (i_last !== want.last) note_mismatch("last", 32'(want.last), 32'(i_last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                relay_on[i]    = 1'b0;
                mono_period[i] = '0;
                mono_count[i]  = '0;
                done_flag[i]   = 1'b0;
            end
            expected_results.delete();
        end else begin
            if (i_req_valid && i_req_ready) predict_beat();
            if (i_res_valid && i_res_ready) check_result();
        end
        outstanding_total = expected_results.size();
    end

endmodule

// ===== test/testbench.sv =====
// Top level of the testbench: clock, reset, request stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps

module testbench;

    import drmc_pkg::*;

    // Opcodes six and seven have no enum member; they must be rejected by the block.
    localparam logic [2:0] OP_RESERVED_6 = 3'd6;
    localparam logic [2:0] OP_RESERVED_7 = 3'd7;

    localparam logic [7:0] RELAY_ONE = 8'd1;
    localparam logic [7:0] RELAY_TWO = 8'd2;

    // Number of random request beats in each of the three random phases.
    localparam int PHASE_BEATS  = 470;
    // Length of the long receiver hold-off that fills both internal queues.
    localparam int HOLD_CYCLES  = 120;
    // Cycles allowed after the last expected result for stray late results.
    localparam int DRAIN_CYCLES = 32;
    // Absolute limit of the run; a correct run needs only a small part of it.
    localparam int TIMEOUT_NS   = 2_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_opcode;
    logic [7:0]  i_relay_number;
    logic        i_first_level;
    logic        i_second_level;
    logic [31:0] i_duration;
    logic        i_calc_tick;
    logic        i_message_tick;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_kind;
    logic [1:0]  o_relay_id;
    logic        o_level_one;
    logic        o_level_two;
    logic [31:0] o_period;
    logic [31:0] o_remaining;
    logic        o_last;

    int mismatches;
    int outstanding;

    // Idle probabilities in percent for the sender and the receiver.
    int send_idle_pct = 17;
    int recv_idle_pct = 49;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit hold_request  = 1'b0;

    dual_relay_monoflop_controller dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_relay_number (i_relay_number),
        .i_first_level  (i_first_level),
        .i_second_level (i_second_level),
        .i_duration     (i_duration),
        .i_calc_tick    (i_calc_tick),
        .i_message_tick (i_message_tick),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_relay_id     (o_relay_id),
        .o_level_one    (o_level_one),
        .o_level_two    (o_level_two),
        .o_period       (o_period),
        .o_remaining    (o_remaining),
        .o_last         (o_last)
    );

    // The checker watches both channels beside the block and counts every mismatch.
    relay_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_opcode       (i_opcode),
        .i_relay_number (i_relay_number),
        .i_first_level  (i_first_level),
        .i_second_level (i_second_level),
        .i_duration     (i_duration),
        .i_calc_tick    (i_calc_tick),
        .i_message_tick (i_message_tick),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_kind         (o_kind),
        .i_relay_id     (o_relay_id),
        .i_level_one    (o_level_one),
        .i_level_two    (o_level_two),
        .i_period       (o_period),
        .i_remaining    (o_remaining),
        .i_last         (o_last),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Offers one request beat. It is called at a falling edge, may first leave
    // the channel idle for a random number of cycles, then holds the beat until
    // the block accepts it at a rising edge. Valid stays high on return so that
    // back-to-back beats never drop it in between.
    task automatic send_beat(logic [2:0] op, logic [7:0] rn, logic lv1, logic lv2,
                             logic [31:0] dur, logic calc, logic msg);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_opcode       = op;
        i_relay_number = rn;
        i_first_level  = lv1;
        i_second_level = lv2;
        i_duration     = dur;
        i_calc_tick    = calc;
        i_message_tick = msg;
        i_valid        = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random beats are mostly well formed: valid relay numbers, short monoflops
    // that actually run out, and plenty of ticks. Bad relay numbers, huge
    // durations and unsupported opcodes make up the remainder.
    task automatic send_random_beat();
        int          pick;
        logic [2:0]  op;
        logic [7:0]  rn;
        logic [31:0] dur;
        pick = $urandom_range(99);
        if (pick < 8) begin
            op = OP_SET_BOTH;
        end else if (pick < 16) begin
            op = OP_GET_BOTH;
        end else if (pick < 36) begin
            op = OP_SET_MONO;
        end else if (pick < 46) begin
            op = OP_GET_MONO;
        end else if (pick < 54) begin
            op = OP_SET_ONE;
        end else if (pick < 94) begin
            op = OP_TICK;
        end else begin
            op = $urandom_range(1) ? OP_RESERVED_7 : OP_RESERVED_6;
        end
        if ($urandom_range(9) == 0) begin
            rn = 8'($urandom);
        end else begin
            rn = $urandom_range(1) ? RELAY_TWO : RELAY_ONE;
        end
        dur = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(6));
        send_beat(op, rn, 1'($urandom), 1'($urandom), dur, 1'($urandom), 1'($urandom));
    endtask

    // Receiver: random back-pressure at each falling edge, plus one long
    // hold-off counted here when the stimulus asks for it.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            i_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_opcode       = OP_SET_BOTH;
        i_relay_number = 8'd0;
        i_first_level  = 1'b0;
        i_second_level = 1'b0;
        i_duration     = 32'd0;
        i_calc_tick    = 1'b0;
        i_message_tick = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part. Both relays start off after reset, and the tick bits
        // must be ignored when a command carries them.
        send_beat(OP_GET_BOTH, RELAY_ONE, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0);
        send_beat(OP_SET_BOTH, 8'd0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_beat(OP_GET_BOTH, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_beat(OP_GET_MONO, RELAY_ONE, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0);
        // Relay 1 runs a two-tick monoflop, relay 2 the longest possible one.
        send_beat(OP_SET_MONO, RELAY_ONE, 1'b1, 1'b0, 32'd2, 1'b0, 1'b0);
        send_beat(OP_SET_MONO, RELAY_TWO, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_beat(OP_GET_MONO, RELAY_TWO, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0);
        send_beat(OP_TICK, RELAY_ONE, 1'b0, 1'b0, 32'd0, 1'b1, 1'b0);
        send_beat(OP_TICK, RELAY_ONE, 1'b0, 1'b0, 32'd0, 1'b0, 1'b1);
        // A tick without either tick bit produces no result at all.
        send_beat(OP_TICK, RELAY_ONE, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0);
        // The countdown step runs first, so the same beat reports the expiry.
        send_beat(OP_TICK, RELAY_ONE, 1'b0, 1'b0, 32'd0, 1'b1, 1'b1);
        send_beat(OP_GET_MONO, RELAY_ONE, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0);
        // Both relays expire on one tick and give two done results.
        send_beat(OP_SET_MONO, RELAY_ONE, 1'b0, 1'b0, 32'd1, 1'b0, 1'b0);
        send_beat(OP_SET_MONO, RELAY_TWO, 1'b1, 1'b0, 32'd1, 1'b0, 1'b0);
        send_beat(OP_TICK, RELAY_TWO, 1'b0, 1'b0, 32'd0, 1'b1, 1'b1);
        // A monoflop of length zero only sets the level.
        send_beat(OP_SET_MONO, RELAY_TWO, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0);
        send_beat(OP_GET_MONO, RELAY_TWO, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0);
        // A pending done event survives both kinds of set command.
        send_beat(OP_SET_MONO, RELAY_ONE, 1'b1, 1'b0, 32'd1, 1'b0, 1'b0);
        send_beat(OP_TICK, RELAY_ONE, 1'b0, 1'b0, 32'd0, 1'b1, 1'b0);
        send_beat(OP_SET_ONE, RELAY_ONE, 1'b0, 1'b0, 32'd5, 1'b1, 1'b1);
        send_beat(OP_SET_BOTH, RELAY_ONE, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0);
        send_beat(OP_TICK, RELAY_ONE, 1'b0, 1'b0, 32'd0, 1'b0, 1'b1);
        // Bad relay numbers on every addressed command, then unsupported opcodes.
        send_beat(OP_SET_MONO, 8'd0, 1'b1, 1'b0, 32'd3, 1'b0, 1'b0);
        send_beat(OP_GET_MONO, 8'd3, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0);
        send_beat(OP_SET_ONE, 8'hFF, 1'b1, 1'b1, 32'd0, 1'b0, 1'b0);
        send_beat(OP_RESERVED_6, RELAY_ONE, 1'b1, 1'b1, 32'd7, 1'b1, 1'b1);
        send_beat(OP_RESERVED_7, RELAY_TWO, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0);

        // Random part in three phases: sender mostly busy and receiver slow,
        // then the reverse, then neither side idles.
        repeat (PHASE_BEATS) send_random_beat();
        send_idle_pct = 49;
        recv_idle_pct = 17;
        repeat (PHASE_BEATS) send_random_beat();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // The receiver now holds off for a long stretch while beats keep coming,
        // so both queues fill up and the block has to stall its input.
        hold_request = 1'b1;
        repeat (PHASE_BEATS) send_random_beat();
        i_valid = 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== dual_relay_monoflop_controller.f =====
hw/rtl/drmc_pkg.sv
hw/rtl/drmc_front.sv
hw/rtl/drmc_cmd_queue.sv
hw/rtl/drmc_back.sv
hw/rtl/dual_relay_monoflop_controller.sv
test/relay_result_checker.sv
test/testbench.sv
